// ----- hw/rtl/assert_macros.svh -----
// Assertion macros included by the solver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define QRS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/qrs_pkg.sv -----
// Shared constants and types of the quadratic root solver
`default_nettype none
package qrs_pkg;
	localparam int COEF_WIDTH_DEF   = 16;
	localparam int RESULT_WIDTH_DEF = 32;
	// -b scaled to units of 2^-15
	localparam int NB_SHIFT  = 15;
	// |D| scaled before the square root
	localparam int RAD_SHIFT = 30;

	typedef enum logic [1:0] {
		KIND_TWO_REAL = 2'd0,
		KIND_DOUBLE   = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_DEGEN    = 2'd3
	} root_kind_t;
endpackage
`default_nettype wire

// ----- hw/rtl/qrs_coef_if.sv -----
// Request channel carrying the three coefficients
`default_nettype none
interface qrs_coef_if #(
	parameter int W = qrs_pkg::COEF_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] coef_a;
	logic signed [W-1:0] coef_b;
	logic signed [W-1:0] coef_c;

	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_root_if.sv -----
// Result channel carrying root kind, the two values and a saturation flag
`default_nettype none
interface qrs_root_if #(
	parameter int W = qrs_pkg::RESULT_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          root_kind;
	logic signed [W-1:0] first_value;
	logic signed [W-1:0] second_value;
	logic                saturated;

	modport source (output valid, output root_kind, output first_value, output second_value,
		output saturated, input ready);
	modport sink   (input valid, input root_kind, input first_value, input second_value,
		input saturated, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root
`default_nettype none
module qrs_sqrt_cell #(
	parameter int RADW = 64,
	parameter int SW   = 32,
	parameter int SBW  = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [SW+1:0]   in_rem,
	input  wire logic [RADW-1:0] in_rad,
	input  wire logic [SW-1:0]   in_root,
	input  wire logic [SBW-1:0]  in_side,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [SW+1:0]        out_rem,
	output logic [RADW-1:0]      out_rad,
	output logic [SW-1:0]        out_root,
	output logic [SBW-1:0]       out_side
);
	logic [SW+1:0] t;
	logic [SW+1:0] trial;
	logic          fits;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		t     = {in_rem[SW-1:0], in_rad[RADW-1:RADW-2]};
		trial = {in_root, 2'b01};
		fits  = (t >= trial);
	end

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_rem  <= fits ? (t - trial) : t;
			out_root <= {in_root[SW-2:0], fits};
			out_rad  <= in_rad << 2;
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_div_cell.sv -----
// One quotient-bit cell of the two-lane pipelined divider
`default_nettype none
module qrs_div_cell #(
	parameter int NMW = 33,
	parameter int DW  = 16,
	parameter int SBW = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [DW-1:0]  in_div,
	input  wire logic [NMW-1:0] in_num [2],
	input  wire logic [DW:0]    in_rem [2],
	input  wire logic [NMW-1:0] in_quo [2],
	input  wire logic [SBW-1:0] in_side,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [DW-1:0]       out_div,
	output logic [NMW-1:0]      out_num [2],
	output logic [DW:0]         out_rem [2],
	output logic [NMW-1:0]      out_quo [2],
	output logic [SBW-1:0]      out_side
);
	logic [DW:0] t    [2];
	logic        fits [2];

	// restoring step per lane: shift in next numerator bit, subtract if it fits
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			t[i]    = {in_rem[i][DW-1:0], in_num[i][NMW-1]};
			fits[i] = (t[i] >= {1'b0, in_div});
		end
	end

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			for (int i = 0; i < 2; i++) begin
				out_rem[i] <= fits[i] ? (t[i] - {1'b0, in_div}) : t[i];
				out_quo[i] <= {in_quo[i][NMW-2:0], fits[i]};
				out_num[i] <= in_num[i] << 1;
			end
			out_div  <= in_div;
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_root_solver_top.sv -----
// Quadratic root solver: discriminant, square-root cell chain, divider cell chain
// Registers in order: products, discriminant, one cell per square root digit, numerators,
// one cell per quotient bit, output; SW = square root digits, NMW = quotient bits.
// Throughput: one coefficient set per cycle; each cell stalls only when its successor is full.
// Reset clears every stage valid bit; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module quadratic_root_solver_top #(
	parameter int COEF_WIDTH   = qrs_pkg::COEF_WIDTH_DEF,
	parameter int RESULT_WIDTH = qrs_pkg::RESULT_WIDTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	qrs_coef_if.sink    coef,
	qrs_root_if.source  root
);
	localparam int CW   = COEF_WIDTH;
	localparam int PW   = 2 * CW;
	localparam int DNW  = 2 * CW + 2;
	localparam int DMW  = 2 * CW + 1;
	localparam int XW   = DMW + qrs_pkg::RAD_SHIFT;
	localparam int RADW = XW + (XW % 2);
	localparam int SW   = RADW / 2;
	localparam int NBW  = CW + qrs_pkg::NB_SHIFT + 1;
	localparam int NMW  = ((CW + qrs_pkg::NB_SHIFT > SW) ? CW + qrs_pkg::NB_SHIFT : SW) + 1;
	localparam int QW   = NMW + 1;
	localparam int EW   = (QW > RESULT_WIDTH) ? QW : RESULT_WIDTH;
	localparam int SQB  = 2 + NBW + CW;
	localparam int DVB  = 4;
	localparam logic signed [EW-1:0] CLIP_HI = EW'((65'(1) << (RESULT_WIDTH - 1)) - 65'(1));
	localparam logic signed [EW-1:0] CLIP_LO = -CLIP_HI - EW'(1);
	localparam logic signed [RESULT_WIDTH-1:0] R_HI = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
	localparam logic signed [RESULT_WIDTH-1:0] R_LO = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

	// stage 1: products and scaled -b
	logic                  v_s1, rdy_s1;
	logic signed [PW-1:0]  bb_s1, ac_s1;
	logic signed [CW-1:0]  a_s1;
	logic signed [NBW-1:0] nb_s1;
	// stage 2: discriminant and kind
	logic                  v_s2, rdy_s2;
	qrs_pkg::root_kind_t   kind_s2;
	logic [DMW-1:0]        dmag_s2;
	logic signed [NBW-1:0] nb_s2;
	logic signed [CW-1:0]  a_s2;
	logic signed [DNW-1:0] dn;
	// stage 3: numerators and signs
	logic                  v_s3, rdy_s3;
	qrs_pkg::root_kind_t   kind_s3;
	logic                  neg1_s3, neg2_s3;
	logic [CW-1:0]         amag_s3;
	logic [NMW-1:0]        nmag1_s3, nmag2_s3;
	// stage 4: output register
	logic                  v_s4, rdy_s4;

	assign rdy_s1     = !v_s1 || rdy_s2;
	assign coef.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			bb_s1 <= coef.coef_b * coef.coef_b;
			ac_s1 <= coef.coef_a * coef.coef_c;
			a_s1  <= coef.coef_a;
			nb_s1 <= -(NBW'(coef.coef_b) <<< qrs_pkg::NB_SHIFT);
		end
	end

	// discriminant D = b*b - 4*a*c
	assign dn = DNW'(bb_s1) - (DNW'(ac_s1) <<< 2);

	logic sq_v [SW+1];
	logic sq_r [SW+1];
	logic [SW+1:0]  sq_rem  [SW+1];
	logic [RADW-1:0] sq_rad [SW+1];
	logic [SW-1:0]  sq_root [SW+1];
	logic [SQB-1:0] sq_side [SW+1];

	assign rdy_s2 = !v_s2 || sq_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			priority if (a_s1 == '0) kind_s2 <= qrs_pkg::KIND_DEGEN;
			else if (dn == '0)       kind_s2 <= qrs_pkg::KIND_DOUBLE;
			else if (dn[DNW-1])      kind_s2 <= qrs_pkg::KIND_COMPLEX;
			else                     kind_s2 <= qrs_pkg::KIND_TWO_REAL;
			dmag_s2 <= dn[DNW-1] ? DMW'(-dn) : DMW'(dn);
			nb_s2   <= nb_s1;
			a_s2    <= a_s1;
		end
	end

	// square root of |D| * 2^30, one result digit per cell
	logic [RADW-1:0] rad0;
	assign rad0       = RADW'(dmag_s2) << qrs_pkg::RAD_SHIFT;
	assign sq_v[0]    = v_s2;
	assign sq_rem[0]  = '0;
	assign sq_rad[0]  = rad0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {kind_s2, nb_s2, a_s2};

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		qrs_sqrt_cell #(.RADW(RADW), .SW(SW), .SBW(SQB)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(sq_v[i]), .in_ready(sq_r[i]),
			.in_rem(sq_rem[i]), .in_rad(sq_rad[i]), .in_root(sq_root[i]),
			.in_side(sq_side[i]),
			.out_valid(sq_v[i+1]), .out_ready(sq_r[i+1]),
			.out_rem(sq_rem[i+1]), .out_rad(sq_rad[i+1]), .out_root(sq_root[i+1]),
			.out_side(sq_side[i+1])
		);
	end

	// numerators: -b*2^15 +/- S, or S for the imaginary part
	qrs_pkg::root_kind_t   kind_sq;
	logic signed [NBW-1:0] nb_sq;
	logic signed [CW-1:0]  a_sq;
	logic signed [NMW:0]   nbx, sx, n1, n2;

	always_comb begin
		kind_sq = qrs_pkg::root_kind_t'(sq_side[SW][SQB-1 -: 2]);
		nb_sq   = sq_side[SW][CW +: NBW];
		a_sq    = sq_side[SW][CW-1:0];
		nbx     = (NMW+1)'(nb_sq);
		sx      = (NMW+1)'($signed({1'b0, sq_root[SW]}));
		n1      = (kind_sq == qrs_pkg::KIND_TWO_REAL) ? nbx + sx : nbx;
		n2      = (kind_sq == qrs_pkg::KIND_COMPLEX) ? sx : nbx - sx;
	end

	logic dv_v [NMW+1];
	logic dv_r [NMW+1];
	logic [CW-1:0]  dv_div  [NMW+1];
	logic [NMW-1:0] dv_num  [NMW+1][2];
	logic [CW:0]    dv_rem  [NMW+1][2];
	logic [NMW-1:0] dv_quo  [NMW+1][2];
	logic [DVB-1:0] dv_side [NMW+1];

	assign sq_r[SW] = rdy_s3;
	assign rdy_s3   = !v_s3 || dv_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= sq_v[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			kind_s3  <= kind_sq;
			neg1_s3  <= n1[NMW] ^ a_sq[CW-1];
			neg2_s3  <= n2[NMW] ^ a_sq[CW-1];
			amag_s3  <= a_sq[CW-1] ? CW'(-a_sq) : CW'(a_sq);
			nmag1_s3 <= n1[NMW] ? NMW'(-n1) : NMW'(n1);
			nmag2_s3 <= n2[NMW] ? NMW'(-n2) : NMW'(n2);
		end
	end

	// two divisions by |a|, one quotient bit per cell
	assign dv_v[0]      = v_s3;
	assign dv_div[0]    = amag_s3;
	assign dv_num[0][0] = nmag1_s3;
	assign dv_num[0][1] = nmag2_s3;
	assign dv_rem[0][0] = '0;
	assign dv_rem[0][1] = '0;
	assign dv_quo[0][0] = '0;
	assign dv_quo[0][1] = '0;
	assign dv_side[0]   = {kind_s3, neg1_s3, neg2_s3};

	for (genvar i = 0; i < NMW; i++) begin : g_div
		qrs_div_cell #(.NMW(NMW), .DW(CW), .SBW(DVB)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(dv_v[i]), .in_ready(dv_r[i]),
			.in_div(dv_div[i]), .in_num(dv_num[i]), .in_rem(dv_rem[i]),
			.in_quo(dv_quo[i]), .in_side(dv_side[i]),
			.out_valid(dv_v[i+1]), .out_ready(dv_r[i+1]),
			.out_div(dv_div[i+1]), .out_num(dv_num[i+1]), .out_rem(dv_rem[i+1]),
			.out_quo(dv_quo[i+1]), .out_side(dv_side[i+1])
		);
	end

	// sign, clip and degenerate override
	function automatic logic signed [EW-1:0] clip_value(input logic signed [EW-1:0] v);
		if (v > CLIP_HI) return CLIP_HI;
		if (v < CLIP_LO) return CLIP_LO;
		return v;
	endfunction

	qrs_pkg::root_kind_t  kind_dv;
	logic signed [QW-1:0] q1, q2;
	logic signed [EW-1:0] e1, e2, c1, c2;
	logic                 degen;

	always_comb begin
		kind_dv = qrs_pkg::root_kind_t'(dv_side[NMW][3:2]);
		degen   = (kind_dv == qrs_pkg::KIND_DEGEN);
		q1 = dv_side[NMW][1] ? -$signed({1'b0, dv_quo[NMW][0]}) : $signed({1'b0, dv_quo[NMW][0]});
		q2 = dv_side[NMW][0] ? -$signed({1'b0, dv_quo[NMW][1]}) : $signed({1'b0, dv_quo[NMW][1]});
		e1 = EW'(q1);
		e2 = EW'(q2);
		c1 = clip_value(e1);
		c2 = clip_value(e2);
	end

	assign dv_r[NMW] = rdy_s4;
	assign rdy_s4    = !v_s4 || root.ready;
	assign root.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= dv_v[NMW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			root.root_kind    <= kind_dv;
			root.first_value  <= degen ? '0 : RESULT_WIDTH'(c1);
			root.second_value <= degen ? '0 : RESULT_WIDTH'(c2);
			root.saturated    <= !degen && ((c1 != e1) || (c2 != e2));
		end
	end

	`QRS_ASSERT(a_degen_zero, clk, arst_n, root.valid && root.root_kind == qrs_pkg::KIND_DEGEN |-> root.first_value == '0 && root.second_value == '0 && !root.saturated, "degenerate result not zero")
	`QRS_ASSERT(a_double_equal, clk, arst_n, root.valid && root.root_kind == qrs_pkg::KIND_DOUBLE |-> root.first_value == root.second_value, "double root values differ")
	`QRS_ASSERT(a_sat_bound, clk, arst_n, root.valid && root.saturated |-> root.first_value == R_HI || root.first_value == R_LO || root.second_value == R_HI || root.second_value == R_LO, "saturated without a clipped value")
endmodule
`default_nettype wire
